// ----- sv/ogm_pkg.sv -----
// Shared types, field widths and codes of the occupancy grid mapper.
package ogm_pkg;

  // Field widths of the stream items and configuration registers.
  localparam int COORD_W   = 17;
  localparam int CELL_W    = 10;
  localparam int LIMIT_W   = 17;
  localparam int GCFG_W    = 9;
  localparam int ROW_W     = 8;
  localparam int WORDSEL_W = 2;
  localparam int WORD_W    = 64;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Internal widths. Active grid size never exceeds 511, so ten bits hold it.
  localparam int G_W   = 10;
  localparam int DIV_W = 14;
  localparam int NUM_W = 18;
  localparam int DEN_W = 15;
  localparam int QUO_W = 13;
  localparam int POS_W = 16;

  // Reset values of the configuration registers.
  localparam logic [CELL_W-1:0]  CELL_SIZE_RST = 10'd45;
  localparam logic [LIMIT_W-1:0] HEIGHT_RST    = 17'd1000;
  localparam logic [GCFG_W-1:0]  GRID_RST      = 9'd177;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SIZE = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_GRID      = 2'd2
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_POINT = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MARKED  = 3'd0,
    ST_ABOVE   = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_READ    = 3'd3,
    ST_CLEARED = 3'd4,
    ST_BADREAD = 3'd5
  } status_e;

  // Request and response of the bit-serial divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- sv/ogm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module ogm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ogm_div.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module ogm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ogm_pkg::div_req_t req_i,
  output ogm_pkg::div_rsp_t rsp_o
);

  import ogm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] nq_q, nq_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  always_comb begin
    shifted = {rem_q, nq_q[NUM_W-1]};
    fits    = shifted >= {1'b0, den_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    nq_d    = nq_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      den_d = req_i.den;
      nq_d  = req_i.num;
    end else if (run_q) begin
      // The remainder stays below the divisor, so the difference fits.
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      nq_d  = {nq_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nq_q  <= nq_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = nq_q;

endmodule

// ----- sv/occupancy_grid_mapper_core.sv -----
// Flow: a point passes decode, the 18-step bit-serial division of x and y, placement and a
// read-modify-write of its grid word; a read passes decode and one registered memory read; a
// clear sweeps all GRID_MAX*ROW_WORDS words of the grid memory (1024 at the default).
// Throughput: one request at a time; the next one is taken while a result waits.
// Reset: configuration returns to its defaults and a clearing pass over all GRID_MAX*ROW_WORDS
// words zeroes the grid memory, with s_axis_tready low until it ends.
module occupancy_grid_mapper_core #(
  parameter int GRID_MAX = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x[16:0], point_y[33:17], point_z[50:34], read_row[58:51], read_word[60:59]
  input  logic [ogm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // op[1:0]
  input  logic [ogm_pkg::OP_W-1:0]            s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cells_word[63:0], cell_row[71:64], cell_col[79:72]
  output logic [ogm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // status[2:0]
  output logic [ogm_pkg::STATUS_W-1:0]        m_axis_tuser,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ogm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ogm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import ogm_pkg::*;

  // The grid is stored row by row, ROW_WORDS 64-bit words per row.
  localparam int ROW_WORDS = (GRID_MAX + 63) / 64;
  localparam int DEPTH     = GRID_MAX * ROW_WORDS;
  localparam int AW        = $clog2(DEPTH);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_PLACE  = 8'b0001_0000,
    S_RMW    = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  // Control state.
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              clr_report_q, clr_report_d;
  logic              m_valid_q, m_valid_d;

  // Configuration registers.
  logic [CELL_W-1:0]  cell_size_q;
  logic [LIMIT_W-1:0] height_q;
  logic [GCFG_W-1:0]  grid_q;

  // Request fields held for the duration of the work.
  logic [OP_W-1:0]      op_q, op_d;
  logic [COORD_W-1:0]   x_q, x_d;
  logic [COORD_W-1:0]   y_q, y_d;
  logic [COORD_W-1:0]   z_q, z_d;
  logic [ROW_W-1:0]     rrow_q, rrow_d;
  logic [WORDSEL_W-1:0] rword_q, rword_d;

  // Cell position and the address of its word.
  logic [POS_W-1:0] row_q, row_d;
  logic [POS_W-1:0] col_q, col_d;
  logic [AW-1:0]    addr_q, addr_d;

  // Finished result and the output register.
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [WORD_W-1:0]   res_word_q, res_word_d;
  logic [ROW_W-1:0]    res_row_q, res_row_d;
  logic [ROW_W-1:0]    res_col_q, res_col_d;
  logic [STATUS_W-1:0] m_status_q, m_status_d;
  logic [WORD_W-1:0]   m_word_q, m_word_d;
  logic [ROW_W-1:0]    m_row_q, m_row_d;
  logic [ROW_W-1:0]    m_col_q, m_col_d;

  // Derived configuration.
  logic [CELL_W-1:0] cs_eff;
  logic [DIV_W-1:0]  div10;
  logic [DEN_W-1:0]  den20;
  logic [G_W-1:0]    g;
  logic [G_W-1:0]    g_half;

  // Memory port and dividers.
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  div_req_t          div_x_req, div_y_req;
  div_rsp_t          div_x_rsp, div_y_rsp;

  logic              in_take;
  logic              out_free;
  logic [G_W-1:0]    read_left;
  logic [WORD_W-1:0] read_mask;

  // 2*|v| + d, the numerator of the rounded division.
  function automatic logic [NUM_W-1:0] round_num(input logic [COORD_W-1:0] v,
                                                 input logic [DIV_W-1:0] d);
    logic [COORD_W:0] ext;
    logic [COORD_W:0] mag;
    ext = {v[COORD_W-1], v};
    mag = v[COORD_W-1] ? (~ext + 1'b1) : ext;
    return {mag[COORD_W-1:0], 1'b0} + NUM_W'(d);
  endfunction

  // Signed cell count shifted by half the grid size.
  function automatic logic [POS_W-1:0] to_pos(input logic neg,
                                              input logic [NUM_W-1:0] quo,
                                              input logic [G_W-1:0] half);
    logic [POS_W-1:0] q;
    q = POS_W'(quo[QUO_W-1:0]);
    if (neg) begin
      q = ~q + 1'b1;
    end
    return q + POS_W'(half);
  endfunction

  // A position lies on the grid when it is non-negative and below the size.
  function automatic logic on_grid(input logic [POS_W-1:0] p, input logic [G_W-1:0] size);
    return (p[POS_W-1:G_W] == '0) && (p[G_W-1:0] < size);
  endfunction

  // Configuration writes are always taken; an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CELL_SIZE_RST;
      height_q    <= HEIGHT_RST;
      grid_q      <= GRID_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CELL_SIZE: cell_size_q <= cfg_data_i[CELL_W-1:0];
        CFG_HEIGHT:    height_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_GRID:      grid_q      <= cfg_data_i[GCFG_W-1:0];
        default:       ;
      endcase
    end
  end

  // A zero cell size acts as one; the rounding term is 10*cs and the divisor 20*cs millimetres.
  always_comb begin
    cs_eff = (cell_size_q == '0) ? CELL_W'(1) : cell_size_q;
    div10  = DIV_W'(cs_eff) * DIV_W'(10);
    den20  = DEN_W'(cs_eff) * DEN_W'(20);
  end

  // Active grid size is the register clamped to the range 2..GRID_MAX.
  always_comb begin
    if (grid_q < GCFG_W'(2)) begin
      g = G_W'(2);
    end else if (int'(grid_q) > GRID_MAX) begin
      g = G_W'(GRID_MAX);
    end else begin
      g = G_W'(grid_q);
    end
    g_half = g >> 1;
  end

  // Columns of the read word that lie at or past the grid edge read as zero.
  always_comb begin
    read_left = g - G_W'({rword_q, 6'd0});
    if (read_left < G_W'(WORD_W)) begin
      read_mask = ~({WORD_W{1'b1}} << read_left[5:0]);
    end else begin
      read_mask = {WORD_W{1'b1}};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Both dividers start together and finish together.
  always_comb begin
    div_x_req.start = (state_q == S_DECODE) && (op_q == OP_POINT) &&
                      ($signed(z_q) < $signed(height_q));
    div_x_req.num   = round_num(x_q, div10);
    div_x_req.den   = den20;
    div_y_req.start = div_x_req.start;
    div_y_req.num   = round_num(y_q, div10);
    div_y_req.den   = den20;
  end

  ogm_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_x_req),
    .rsp_o  (div_x_rsp)
  );

  ogm_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_y_req),
    .rsp_o  (div_y_rsp)
  );

  // Sequencer: every memory access and result hand-off goes through here.
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    clr_report_d = clr_report_q;
    m_valid_d    = m_valid_q;

    op_d    = op_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    rrow_d  = rrow_q;
    rword_d = rword_q;
    row_d   = row_q;
    col_d   = col_q;
    addr_d  = addr_q;

    res_status_d = res_status_q;
    res_word_d   = res_word_q;
    res_row_d    = res_row_q;
    res_col_d    = res_col_q;
    m_status_d   = m_status_q;
    m_word_d     = m_word_q;
    m_row_d      = m_row_q;
    m_col_d      = m_col_q;

    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clr_cnt_d = '0;
          if (clr_report_q) begin
            res_status_d = ST_CLEARED;
            res_word_d   = '0;
            res_row_d    = '0;
            res_col_d    = '0;
            state_d      = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_take) begin
          op_d    = s_axis_tuser;
          x_d     = s_axis_tdata[16:0];
          y_d     = s_axis_tdata[33:17];
          z_d     = s_axis_tdata[50:34];
          rrow_d  = s_axis_tdata[58:51];
          rword_d = s_axis_tdata[60:59];
          // The undefined op is taken and dropped without a result.
          if (s_axis_tuser == OP_CLEAR || s_axis_tuser == OP_POINT ||
              s_axis_tuser == OP_READ) begin
            state_d = S_DECODE;
          end
        end
      end

      S_DECODE: begin
        res_word_d = '0;
        res_row_d  = '0;
        res_col_d  = '0;
        case (op_q)
          OP_CLEAR: begin
            clr_cnt_d    = '0;
            clr_report_d = 1'b1;
            state_d      = S_CLEAR;
          end
          OP_POINT: begin
            if (div_x_req.start) begin
              state_d = S_DIV;
            end else begin
              res_status_d = ST_ABOVE;
              state_d      = S_DONE;
            end
          end
          OP_READ: begin
            if ((G_W'(rrow_q) >= g) || (G_W'({rword_q, 6'd0}) >= g)) begin
              res_status_d = ST_BADREAD;
              state_d      = S_DONE;
            end else begin
              ram_addr = AW'(int'(rrow_q) * ROW_WORDS + int'(rword_q));
              state_d  = S_READ;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_DIV: begin
        if (div_x_rsp.done) begin
          row_d   = to_pos(y_q[COORD_W-1], div_y_rsp.quo, g_half);
          col_d   = to_pos(x_q[COORD_W-1], div_x_rsp.quo, g_half);
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        if (on_grid(row_q, g) && on_grid(col_q, g)) begin
          addr_d   = AW'(int'(row_q[G_W-1:0]) * ROW_WORDS + int'(col_q[G_W-1:6]));
          ram_addr = addr_d;
          state_d  = S_RMW;
        end else begin
          res_status_d = ST_OUTSIDE;
          state_d      = S_DONE;
        end
      end

      S_RMW: begin
        // The word read last cycle comes back with the cell's bit set.
        ram_we       = 1'b1;
        ram_addr     = addr_q;
        ram_wdata    = ram_rdata | (WORD_W'(1) << col_q[5:0]);
        res_status_d = ST_MARKED;
        res_row_d    = row_q[ROW_W-1:0];
        res_col_d    = col_q[ROW_W-1:0];
        state_d      = S_DONE;
      end

      S_READ: begin
        res_status_d = ST_READ;
        res_word_d   = ram_rdata & read_mask;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_word_d   = res_word_q;
          m_row_d    = res_row_q;
          m_col_d    = res_col_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_report_q <= clr_report_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    x_q          <= x_d;
    y_q          <= y_d;
    z_q          <= z_d;
    rrow_q       <= rrow_d;
    rword_q      <= rword_d;
    row_q        <= row_d;
    col_q        <= col_d;
    addr_q       <= addr_d;
    res_status_q <= res_status_d;
    res_word_q   <= res_word_d;
    res_row_q    <= res_row_d;
    res_col_q    <= res_col_d;
    m_status_q   <= m_status_d;
    m_word_q     <= m_word_d;
    m_row_q      <= m_row_d;
    m_col_q      <= m_col_d;
  end

  ogm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_col_q, m_row_q, m_word_q};
  assign m_axis_tuser  = m_status_q;

endmodule
